// ===== hw/rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, pattern kind codes and character helpers for the
// timestamp pattern parser.
// ----------------------------------------------------------------------------
package pts_pkg;

  // pattern kind codes
  typedef logic [3:0] kind_t;
  localparam kind_t KIND_NONE   = 4'd0;
  localparam kind_t KIND_YEAR   = 4'd1;
  localparam kind_t KIND_MONTH  = 4'd2;
  localparam kind_t KIND_DAY    = 4'd3;
  localparam kind_t KIND_HOUR   = 4'd4;
  localparam kind_t KIND_MINUTE = 4'd5;
  localparam kind_t KIND_SECOND = 4'd6;
  localparam kind_t KIND_MILLI  = 4'd7;
  localparam kind_t KIND_MICRO  = 4'd8;
  localparam kind_t KIND_NANO   = 4'd9;

  // run length limits
  typedef logic [2:0] run_len_t;
  localparam run_len_t RUN_MAX      = 3'd5;
  localparam run_len_t FULL_YEAR    = 3'd4;
  localparam run_len_t FULL_SUBSEC  = 3'd3;
  localparam run_len_t FULL_DEFAULT = 3'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // captured record
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [9:0]  milli;
    logic [9:0]  micro;
    logic [9:0]  nano;
    logic        valid;
  } rec_t;

  // full parser state
  typedef struct packed {
    kind_t           kind;
    run_len_t        run_len;
    logic [2:0][7:0] recent;   // newest text character in slot 0
    logic            ended;
    rec_t            rec;
  } pts_state_t;

  localparam pts_state_t ST_CLEAR = '0;

  // pattern letter to kind
  function automatic kind_t kind_of(input logic [7:0] c);
    kind_t k;
    case (c)
      "y", "Y": k = KIND_YEAR;
      "M":      k = KIND_MONTH;
      "d", "D": k = KIND_DAY;
      "H", "h": k = KIND_HOUR;
      "m":      k = KIND_MINUTE;
      "s", "S": k = KIND_SECOND;
      "z", "Z": k = KIND_MILLI;
      "v", "V": k = KIND_MICRO;
      "n", "N": k = KIND_NANO;
      default:  k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // low nibble of an ascii digit is its value
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    return c[3:0];
  endfunction

endpackage

// ===== hw/rtl/pts_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_step
// Next-state logic for one format/text character pair: run tracking,
// digit check and decimal field capture.
// ----------------------------------------------------------------------------
module pts_step
  import pts_pkg::*;
(
  input  pts_state_t  cur_state,
  input  logic [7:0]  format_char,
  input  logic [7:0]  text_char,
  input  logic        first_pair,
  output pts_state_t  nxt_state
);

  pts_state_t base;
  kind_t      kind;
  run_len_t   run_len;
  run_len_t   full_len;
  logic [3:0] d0, d1, d2, d3;
  logic       ok2, ok3, ok4;
  logic [6:0]  val2;
  logic [9:0]  val3;
  logic [13:0] val4;
  logic        capture_ok;

  // start from a cleared record on the first pair
  assign base = first_pair ? ST_CLEAR : cur_state;
  assign kind = kind_of(format_char);

  // digit history values
  assign d0 = digit_val(text_char);
  assign d1 = digit_val(base.recent[0]);
  assign d2 = digit_val(base.recent[1]);
  assign d3 = digit_val(base.recent[2]);

  assign ok2 = is_digit(text_char) && is_digit(base.recent[0]);
  assign ok3 = ok2 && is_digit(base.recent[1]);
  assign ok4 = ok3 && is_digit(base.recent[2]);

  // decimal values for two, three and four digit fields
  assign val2 = 7'(d1) * 7'd10 + 7'(d0);
  assign val3 = 10'(d2) * 10'd100 + 10'(d1) * 10'd10 + 10'(d0);
  assign val4 = 14'(d3) * 14'd1000 + 14'(d2) * 14'd100 + 14'(d1) * 14'd10 + 14'(d0);

  // run length after this pair
  always_comb begin
    if (kind == base.kind) begin
      run_len = (base.run_len < RUN_MAX) ? base.run_len + 3'd1 : base.run_len;
    end else begin
      run_len = 3'd1;
    end
    if (kind == KIND_YEAR) begin
      full_len = FULL_YEAR;
      capture_ok = ok4;
    end else if (kind >= KIND_MILLI) begin
      full_len = FULL_SUBSEC;
      capture_ok = ok3;
    end else begin
      full_len = FULL_DEFAULT;
      capture_ok = ok2;
    end
  end

  // state update
  always_comb begin
    nxt_state = base;
    if (!base.ended) begin
      if (format_char == 8'd0 || text_char == 8'd0) begin
        nxt_state.ended = 1'b1;
      end else begin
        if (kind == KIND_NONE) begin
          nxt_state.kind    = KIND_NONE;
          nxt_state.run_len = '0;
        end else begin
          nxt_state.kind    = kind;
          nxt_state.run_len = run_len;
          if (run_len == full_len && capture_ok) begin
            nxt_state.rec.valid = 1'b1;
            case (kind)
              KIND_YEAR:   nxt_state.rec.year   = val4;
              KIND_MONTH:  nxt_state.rec.month  = val2;
              KIND_DAY:    nxt_state.rec.day    = val2;
              KIND_HOUR:   nxt_state.rec.hour   = val2;
              KIND_MINUTE: nxt_state.rec.minute = val2;
              KIND_SECOND: nxt_state.rec.second = val2;
              KIND_MILLI:  nxt_state.rec.milli  = val3;
              KIND_MICRO:  nxt_state.rec.micro  = val3;
              default:     nxt_state.rec.nano   = val3;
            endcase
          end
        end
        nxt_state.recent[2] = base.recent[1];
        nxt_state.recent[1] = base.recent[0];
        nxt_state.recent[0] = text_char;
      end
    end
  end

endmodule

// ===== hw/rtl/pattern_timestamp_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_timestamp_parser_core
// Parses a timestamp from paired format/text character items and emits
// the captured fields after the last pair.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | format_char, text_char,
//          |           |                      | first_pair, last_pair
//  out_    | output    | out_valid / out_stall| nine field values, record_valid
//
// One item per cycle is accepted while in_stall is low. An item is held in the
// input register and then updates the parser state; a last pair loads the
// result register in the same update, and its record is emitted from there.
// Reset clears state and both stage valids. A stalled result holds the
// input stage, which then stalls the input channel.
// ----------------------------------------------------------------------------
module pattern_timestamp_parser_core
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_format_char,
  input  logic [7:0]  in_text_char,
  input  logic        in_first_pair,
  input  logic        in_last_pair,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_year_value,
  output logic [6:0]  out_month_value,
  output logic [6:0]  out_day_value,
  output logic [6:0]  out_hour_value,
  output logic [6:0]  out_minute_value,
  output logic [6:0]  out_second_value,
  output logic [9:0]  out_milli_value,
  output logic [9:0]  out_micro_value,
  output logic [9:0]  out_nano_value,
  output logic        out_record_valid
);

  logic       s_valid_r;
  logic [7:0] s_format_r;
  logic [7:0] s_text_r;
  logic       s_first_r;
  logic       s_last_r;
  pts_state_t st_r;
  pts_state_t st_nxt;
  logic       out_valid_r;
  rec_t       out_rec_r;
  logic       advance;
  logic       fire;

  // stage moves when the result register is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s_valid_r && advance;
  assign in_stall = s_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s_format_r <= in_format_char;
      s_text_r   <= in_text_char;
      s_first_r  <= in_first_pair;
      s_last_r   <= in_last_pair;
    end
  end

  // per-pair next state
  pts_step u_step (
    .cur_state   (st_r),
    .format_char (s_format_r),
    .text_char   (s_text_r),
    .first_pair  (s_first_r),
    .nxt_state   (st_nxt)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s_valid_r && s_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s_last_r) begin
      out_rec_r <= st_nxt.rec;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_year_value   = out_rec_r.year;
  assign out_month_value  = out_rec_r.month;
  assign out_day_value    = out_rec_r.day;
  assign out_hour_value   = out_rec_r.hour;
  assign out_minute_value = out_rec_r.minute;
  assign out_second_value = out_rec_r.second;
  assign out_milli_value  = out_rec_r.milli;
  assign out_micro_value  = out_rec_r.micro;
  assign out_nano_value   = out_rec_r.nano;
  assign out_record_valid = out_rec_r.valid;

endmodule

// ===== tb/pattern_timestamp_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_timestamp_parser_core_tb
// Self-checking bench for the timestamp pattern parser. A behavioral parser
// model runs alongside the block and predicts the record emitted after each
// last pair. Directed sequences hit field extremes, every pattern letter and
// the corner cases: overlong runs, broken digit runs, recapture, termination
// and pairs without a first pair. Random well-formed records mixed with
// noise run under three sender/receiver idle mixes, plus a long receiver
// hold that backs up the input channel.
// ----------------------------------------------------------------------------
module pattern_timestamp_parser_core_tb
  import pts_pkg::*;
();

  localparam int PIPE_DEPTH  = 2;       // stages from item to record: input and result registers
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_format_char;
  logic [7:0]  in_text_char;
  logic        in_first_pair;
  logic        in_last_pair;
  logic        out_valid;
  logic        out_stall;
  logic [13:0] out_year_value;
  logic [6:0]  out_month_value;
  logic [6:0]  out_day_value;
  logic [6:0]  out_hour_value;
  logic [6:0]  out_minute_value;
  logic [6:0]  out_second_value;
  logic [9:0]  out_milli_value;
  logic [9:0]  out_micro_value;
  logic [9:0]  out_nano_value;
  logic        out_record_valid;

  // parser model state
  kind_t      run_kind;
  run_len_t   run_count;
  logic [7:0] text_hist [3];
  logic       parse_done;
  rec_t       captured;
  rec_t       records_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int fail_count;
  int pairs_sent;
  int records_checked;
  int cycle_count;

  pattern_timestamp_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_format_char   (in_format_char),
    .in_text_char     (in_text_char),
    .in_first_pair    (in_first_pair),
    .in_last_pair     (in_last_pair),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year_value   (out_year_value),
    .out_month_value  (out_month_value),
    .out_day_value    (out_day_value),
    .out_hour_value   (out_hour_value),
    .out_minute_value (out_minute_value),
    .out_second_value (out_second_value),
    .out_milli_value  (out_milli_value),
    .out_micro_value  (out_micro_value),
    .out_nano_value   (out_nano_value),
    .out_record_valid (out_record_valid)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pattern_timestamp_parser_core_tb: FAIL");
      $finish;
    end
  end

  // letter class; M and m differ, the rest fold case
  function automatic kind_t pattern_class(input logic [7:0] c);
    kind_t k;
    if (c == "M") k = KIND_MONTH;
    else if (c == "m") k = KIND_MINUTE;
    else begin
      case (c | 8'h20)
        "y":     k = KIND_YEAR;
        "d":     k = KIND_DAY;
        "h":     k = KIND_HOUR;
        "s":     k = KIND_SECOND;
        "z":     k = KIND_MILLI;
        "v":     k = KIND_MICRO;
        "n":     k = KIND_NANO;
        default: k = KIND_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic run_len_t full_run(input kind_t k);
    if (k == KIND_YEAR) return FULL_YEAR;
    if (k == KIND_MILLI || k == KIND_MICRO || k == KIND_NANO) return FULL_SUBSEC;
    return FULL_DEFAULT;
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    case ($urandom_range(15))
      0:  c = "y";
      1:  c = "Y";
      2:  c = "M";
      3:  c = "d";
      4:  c = "D";
      5:  c = "H";
      6:  c = "h";
      7:  c = "m";
      8:  c = "s";
      9:  c = "S";
      10: c = "z";
      11: c = "Z";
      12: c = "v";
      13: c = "V";
      14: c = "n";
      default: c = "N";
    endcase
    return c;
  endfunction

  task automatic clear_parser();
    run_kind   = KIND_NONE;
    run_count  = '0;
    text_hist[0] = 8'd0;
    text_hist[1] = 8'd0;
    text_hist[2] = 8'd0;
    parse_done = 1'b0;
    captured   = '0;
  endtask

  // model update for one accepted pair
  task automatic advance_parser(input logic [7:0] fc, input logic [7:0] tc,
                                input logic first, input logic last);
    kind_t       k;
    run_len_t    need;
    int unsigned value;
    int unsigned scale;
    logic        digits_ok;
    int          i;
    if (first) clear_parser();
    if (!parse_done) begin
      if (fc == 8'd0 || tc == 8'd0) begin
        parse_done = 1'b1;
      end else begin
        k = pattern_class(fc);
        if (k == KIND_NONE) begin
          run_kind  = KIND_NONE;
          run_count = '0;
        end else begin
          if (k == run_kind) begin
            if (run_count < RUN_MAX) run_count++;
          end else begin
            run_count = 3'd1;
          end
          run_kind = k;
          need = full_run(k);
          if (run_count == need) begin
            digits_ok = is_numeral(tc);
            value = int'(tc) - int'(CHAR_ZERO);
            scale = 10;
            for (i = 0; i < int'(need) - 1; i++) begin
              digits_ok &= is_numeral(text_hist[i]);
              value += (int'(text_hist[i]) - int'(CHAR_ZERO)) * scale;
              scale *= 10;
            end
            if (digits_ok) begin
              case (k)
                KIND_YEAR:   captured.year   = value[13:0];
                KIND_MONTH:  captured.month  = value[6:0];
                KIND_DAY:    captured.day    = value[6:0];
                KIND_HOUR:   captured.hour   = value[6:0];
                KIND_MINUTE: captured.minute = value[6:0];
                KIND_SECOND: captured.second = value[6:0];
                KIND_MILLI:  captured.milli  = value[9:0];
                KIND_MICRO:  captured.micro  = value[9:0];
                default:     captured.nano   = value[9:0];
              endcase
              captured.valid = 1'b1;
            end
          end
        end
        text_hist[2] = text_hist[1];
        text_hist[1] = text_hist[0];
        text_hist[0] = tc;
      end
    end
    if (last) records_due.push_back(captured);
  endtask

  // drive one item, with random idle cycles ahead of it
  task automatic send_pair(input logic [7:0] fc, input logic [7:0] tc,
                           input logic first, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_format_char <= fc;
    in_text_char   <= tc;
    in_first_pair  <= first;
    in_last_pair   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_parser(fc, tc, first, last);
    pairs_sent++;
  endtask

  // format and text strings in lockstep
  task automatic send_text(input string fmt, input string txt,
                           input logic first, input logic last);
    int i;
    for (i = 0; i < fmt.len(); i++)
      send_pair(fmt[i], txt[i], first && i == 0, last && i == fmt.len() - 1);
  endtask

  task automatic wait_records_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
  endtask

  // receiver: long hold when requested, else random stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // record checker
  always @(posedge clk) begin : record_check
    rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (records_due.size() == 0) begin
        $error("record with no item pending");
        fail_count++;
      end else begin
        want = records_due.pop_front();
        check_field("year_value",   want.year,   out_year_value);
        check_field("month_value",  want.month,  out_month_value);
        check_field("day_value",    want.day,    out_day_value);
        check_field("hour_value",   want.hour,   out_hour_value);
        check_field("minute_value", want.minute, out_minute_value);
        check_field("second_value", want.second, out_second_value);
        check_field("milli_value",  want.milli,  out_milli_value);
        check_field("micro_value",  want.micro,  out_micro_value);
        check_field("nano_value",   want.nano,   out_nano_value);
        check_field("record_valid", want.valid,  out_record_valid);
        records_checked++;
      end
    end
  end

  // every pattern letter in one record, all nines
  task automatic test_full_record();
    send_text("yYyYMMdDHhmmsSzZzvVvnNn", "99999999999999999999999", 1'b1, 1'b1);
  endtask

  // no first pair: nano run goes overlong, month is overwritten
  task automatic test_continuation();
    send_text("nMM", "107", 1'b0, 1'b1);
  endtask

  // overlong run, separator, zero values, non-digit edges, recapture, termination
  task automatic test_special_cases();
    send_text("yyyyy-ddssmmdd", "12345-00/95:31", 1'b1, 1'b0);
    send_pair(8'h00, "7", 1'b0, 1'b0);
    send_text("MM", "12", 1'b0, 1'b1);
    send_pair("y", 8'h00, 1'b1, 1'b1);
    send_pair("M", "5", 1'b0, 1'b1);
  endtask

  // receiver holds long while the sender keeps offering result items
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 64;
    for (i = 0; i < 40; i++)
      send_pair(pick_letter(), 8'(CHAR_ZERO + $urandom_range(9)), i == 0, 1'b1);
    wait_records_drained();
  endtask

  task automatic send_wellformed_record();
    logic [7:0] fq [$];
    logic [7:0] tq [$];
    logic [7:0] letter;
    logic [7:0] c;
    int         segs;
    int         len;
    int         s;
    int         j;
    segs = $urandom_range(1, 6);
    for (s = 0; s < segs; s++) begin
      letter = pick_letter();
      len = ($urandom_range(99) < 70) ? int'(full_run(pattern_class(letter)))
                                     : $urandom_range(1, 6);
      for (j = 0; j < len; j++) begin
        c = letter;
        if ($urandom_range(99) < 15) c ^= 8'h20;
        fq.push_back(c);
        if ($urandom_range(99) < 90) tq.push_back(8'(CHAR_ZERO + $urandom_range(9)));
        else tq.push_back(8'($urandom_range(1, 255)));
      end
      // optional separator between runs
      if ($urandom_range(99) < 60) begin
        case ($urandom_range(5))
          0: c = "-";
          1: c = ":";
          2: c = " ";
          3: c = ".";
          4: c = "T";
          default: c = 8'($urandom_range(1, 255));
        endcase
        fq.push_back(c);
        tq.push_back(8'($urandom_range(1, 255)));
      end
    end
    // occasional early terminator
    if ($urandom_range(99) < 5) begin
      j = $urandom_range(fq.size() - 1);
      if ($urandom_range(1)) fq[j] = 8'h00;
      else tq[j] = 8'h00;
    end
    for (j = 0; j < fq.size(); j++)
      send_pair(fq[j], tq[j], j == 0, j == fq.size() - 1);
  endtask

  task automatic send_noise();
    int n;
    int j;
    n = $urandom_range(1, 8);
    for (j = 0; j < n; j++)
      send_pair(8'($urandom_range(255)), 8'($urandom_range(255)),
                $urandom_range(99) < 25, $urandom_range(99) < 30);
  endtask

  task automatic test_random_records(input int s_pct, input int r_pct, input int count);
    int start;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = pairs_sent;
    while (pairs_sent - start < count) begin
      if ($urandom_range(99) < 80) send_wellformed_record();
      else send_noise();
    end
    wait_records_drained();
  endtask

  // test sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_format_char = 8'd0;
    in_text_char   = 8'd0;
    in_first_pair  = 1'b0;
    in_last_pair   = 1'b0;
    out_stall      = 1'b0;
    hold_left      = 0;
    send_idle_pct  = 36;
    recv_idle_pct  = 84;
    fail_count     = 0;
    pairs_sent     = 0;
    records_checked = 0;
    cycle_count    = 0;
    clear_parser();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_full_record();
    test_continuation();
    test_special_cases();
    wait_records_drained();
    test_backpressure();
    test_random_records(36, 84, 200);
    test_random_records(84, 36, 200);
    test_random_records(0, 0, 200);
    wait_records_drained();

    $display("covered: all pattern letters, field extremes, overlong and broken runs,");
    $display("termination and long receiver hold; %0d items sent, %0d records checked",
             pairs_sent, records_checked);
    if (fail_count == 0) begin
      $display("pattern_timestamp_parser_core_tb: PASS");
    end else begin
      $display("pattern_timestamp_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pts_pkg.sv
hw/rtl/pts_step.sv
hw/rtl/pattern_timestamp_parser_core.sv
tb/pattern_timestamp_parser_core_tb.sv
